/* hw/rtl/mawjr_pkg.sv */
// Shared types and constants for the moving average with jump reset.
package mawjr_pkg;

	localparam int MAX_WINDOW_DEF = 16;

	localparam int SAMPLE_W = 16;
	localparam int WLEN_W   = 5;
	localparam int JLIM_W   = 15;
	localparam int FILL_W   = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 15;
	localparam int OUT_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT = 1'd1;

	localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = 5'd10;
	localparam logic [JLIM_W-1:0] JUMP_LIMIT_RST = 15'd41;

	typedef struct packed {
		logic                       restart;
		logic signed [SAMPLE_W-1:0] sample;
	} mawjr_item_t;

endpackage

/* hw/rtl/moving_average_with_jump_reset.sv */
// Path: the queue, then engine states IDLE, DROP (if the oldest drops), SETUP, DIV, OUT.
// The engine takes a new sample only after its 16-step serial divider and OUT state are done.
// A two-entry queue lets the front take new samples while a result waits at the output.
// Reset (arst_n low, asynchronous) empties the window, clears the sum and queue,
// and loads window_len = 10 and jump_limit = 41; the sample ring is not cleared.
module moving_average_with_jump_reset import mawjr_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] sample
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] average, [20:16] fill_count
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [WLEN_W-1:0]          window_len_q;
	logic [JLIM_W-1:0]          jump_limit_q;
	logic                       fq_valid;
	logic                       fq_ready;
	mawjr_item_t                fq_item;
	logic                       bq_valid;
	logic                       bq_ready;
	mawjr_item_t                bq_item;
	logic signed [SAMPLE_W-1:0] average;
	logic [FILL_W-1:0]          fill_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_LEN_RST;
			jump_limit_q <= JUMP_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WINDOW_LEN: window_len_q <= cfg_data[WLEN_W-1:0];
				REG_JUMP_LIMIT: jump_limit_q <= cfg_data[JLIM_W-1:0];
				default: begin
					window_len_q <= window_len_q;
				end
			endcase
		end
	end

	mawjr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_sample  (s_axis_tdata),
		.jump_limit (jump_limit_q),
		.q_valid    (fq_valid),
		.q_ready    (fq_ready),
		.q_item     (fq_item)
	);

	mawjr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_item  (fq_item),
		.rd_valid (bq_valid),
		.rd_ready (bq_ready),
		.rd_item  (bq_item)
	);

	mawjr_back #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.window_len  (window_len_q),
		.in_valid    (bq_valid),
		.in_ready    (bq_ready),
		.in_item     (bq_item),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_average (average),
		.out_fill    (fill_count)
	);

	assign m_axis_tdata = {3'b000, fill_count, average};

endmodule

/* hw/rtl/mawjr_front.sv */
// Front end: takes sample beats and flags a window restart on the first sample after reset or on a jump.
module mawjr_front import mawjr_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] in_sample,
	input  logic [JLIM_W-1:0]          jump_limit,
	output logic                       q_valid,
	input  logic                       q_ready,
	output mawjr_item_t                q_item
);

	logic signed [SAMPLE_W-1:0] prev_q;
	logic                       have_prev_q;
	logic signed [SAMPLE_W:0]   diff;
	logic [SAMPLE_W:0]          mag;
	logic                       jump;

	always_comb begin
		diff = {in_sample[SAMPLE_W-1], in_sample} - {prev_q[SAMPLE_W-1], prev_q};
		mag  = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
		jump = mag > {2'b00, jump_limit};
	end

	assign in_ready       = q_ready;
	assign q_valid        = in_valid;
	assign q_item.sample  = in_sample;
	assign q_item.restart = !have_prev_q || jump;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
		end else if (in_valid && q_ready) begin
			prev_q      <= in_sample;
			have_prev_q <= 1'b1;
		end
	end

endmodule

/* hw/rtl/mawjr_fifo.sv */
// Two-entry queue between the front end and the averaging engine.
module mawjr_fifo import mawjr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_valid,
	output logic        wr_ready,
	input  mawjr_item_t wr_item,
	output logic        rd_valid,
	input  logic        rd_ready,
	output mawjr_item_t rd_item
);

	mawjr_item_t slot_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign wr_ready = count_q != 2'd2;
	assign rd_valid = count_q != 2'd0;
	assign rd_item  = slot_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* hw/rtl/mawjr_back.sv */
// Averaging engine: sample ring, running sum and serial divider.
module mawjr_back import mawjr_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [WLEN_W-1:0]          window_len,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  mawjr_item_t                in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] out_average,
	output logic [FILL_W-1:0]          out_fill
);

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SUM_W = SAMPLE_W + CNT_W;
	localparam int ITER_W = $clog2(SAMPLE_W);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DROP  = 5'b00010,
		ST_SETUP = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t                     state_q;
	logic signed [SAMPLE_W-1:0] ring [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0] rd_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [PTR_W-1:0]           oldest_q;
	logic signed [SAMPLE_W-1:0] samp_q;
	logic                       neg_q;
	logic [CNT_W-1:0]           rem_q;
	logic [SAMPLE_W-1:0]        quo_q;
	logic [ITER_W-1:0]          iter_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] avg_q;
	logic [FILL_W-1:0]          fill_q;

	logic [CNT_W-1:0]           win_eff;
	logic [CNT_W:0]             idx_sum;
	logic [PTR_W-1:0]           widx;
	logic                       we;
	logic [PTR_W-1:0]           wa;
	logic signed [SAMPLE_W-1:0] wd;
	logic [SUM_W-1:0]           sum_abs;
	logic [CNT_W:0]             rem_sh;
	logic                       ge;
	logic                       out_free;

	always_comb begin
		if (window_len == '0) begin
			win_eff = CNT_W'(1);
		end else if (int'(window_len) > MAX_WINDOW) begin
			win_eff = CNT_W'(MAX_WINDOW);
		end else begin
			win_eff = CNT_W'(window_len);
		end
	end

	always_comb begin
		idx_sum = {1'b0, cnt_q} + (CNT_W+1)'(oldest_q);
		if (idx_sum >= (CNT_W+1)'(MAX_WINDOW)) begin
			widx = PTR_W'(idx_sum - (CNT_W+1)'(MAX_WINDOW));
		end else begin
			widx = PTR_W'(idx_sum);
		end
	end

	assign in_ready = state_q == ST_IDLE;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		we = 1'b0;
		wa = widx;
		wd = in_item.sample;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_item.restart) begin
						we = 1'b1;
						wa = '0;
					end else if (cnt_q < win_eff) begin
						we = 1'b1;
					end
				end
			end
			ST_DROP: begin
				we = 1'b1;
				wd = samp_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			ring[wa] <= wd;
		end
		rd_q <= ring[oldest_q];
	end

	always_comb begin
		sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		rem_sh  = {rem_q, quo_q[SAMPLE_W-1]};
		ge      = rem_sh >= {1'b0, cnt_q};
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				samp_q <= in_item.sample;
			end
			ST_SETUP: begin
				neg_q  <= sum_q[SUM_W-1];
				rem_q  <= sum_abs[SUM_W-1:SAMPLE_W];
				quo_q  <= sum_abs[SAMPLE_W-1:0];
			end
			ST_DIV: begin
				rem_q <= ge ? CNT_W'(rem_sh - {1'b0, cnt_q}) : CNT_W'(rem_sh);
				quo_q <= {quo_q[SAMPLE_W-2:0], ge};
			end
			default: begin
				samp_q <= samp_q;
			end
		endcase
		if (state_q == ST_OUT && out_free) begin
			avg_q  <= neg_q ? SAMPLE_W'(-quo_q) : SAMPLE_W'(quo_q);
			fill_q <= FILL_W'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			oldest_q    <= '0;
			iter_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_item.restart) begin
							oldest_q <= '0;
							cnt_q    <= CNT_W'(1);
							sum_q    <= SUM_W'(in_item.sample);
							state_q  <= ST_SETUP;
						end else if (cnt_q < win_eff) begin
							cnt_q   <= cnt_q + CNT_W'(1);
							sum_q   <= sum_q + SUM_W'(in_item.sample);
							state_q <= ST_SETUP;
						end else begin
							state_q <= ST_DROP;
						end
					end
				end
				ST_DROP: begin
					sum_q <= sum_q - SUM_W'(rd_q) + SUM_W'(samp_q);
					if (int'(oldest_q) == MAX_WINDOW - 1) begin
						oldest_q <= '0;
					end else begin
						oldest_q <= oldest_q + PTR_W'(1);
					end
					state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					iter_q  <= ITER_W'(SAMPLE_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					iter_q <= iter_q - ITER_W'(1);
					if (iter_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_average = avg_q;
	assign out_fill    = fill_q;

endmodule

/* tb/sv/tb.sv */
// Testbench for the moving average with jump reset: sample walks checked against a window model.
module tb;
	import mawjr_pkg::*;

	typedef struct {
		logic [SAMPLE_W-1:0] average;
		logic [FILL_W-1:0]   fill_count;
	} avg_result_t;

	localparam int LONG_HOLD   = 400;
	localparam int PHASES      = 24;
	localparam int PHASE_ITEMS = 76;
	localparam int SETTLE      = 25;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [SAMPLE_W-1:0]   s_axis_tdata = '0;    // [15:0] sample
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;         // [15:0] average, [20:16] fill_count
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_WINDOW_LEN;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [SAMPLE_W-1:0] sample_q[$];
	avg_result_t         avg_expect_q[$];
	avg_result_t         exp_res;

	logic [SAMPLE_W-1:0] ring_slots[MAX_WINDOW_DEF];
	int window_sum = 0;
	int window_held = 0;
	int ring_oldest = 0;
	int last_sample = 0;
	logic [WLEN_W-1:0] win_len_cfg = WINDOW_LEN_RST;
	logic [JLIM_W-1:0] jump_lim_cfg = JUMP_LIMIT_RST;

	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	bit long_hold_req = 1'b0;
	bit long_hold_done = 1'b0;
	int tx_wait = 0;
	int rx_wait = 0;
	int rx_gap = 0;
	int hold_count = 0;
	int fail_count = 0;
	int walk_pos = 0;

	moving_average_with_jump_reset i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("tb: FAIL");
		$finish;
	end

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic advance_window(input logic [SAMPLE_W-1:0] raw);
		int s;
		int step;
		int win;
		int avg;
		avg_result_t res;
		s = int'($signed(raw));
		if (win_len_cfg == 0)
			win = 1;
		else if (win_len_cfg > MAX_WINDOW_DEF)
			win = MAX_WINDOW_DEF;
		else
			win = int'(win_len_cfg);
		step = s - last_sample;
		if (step < 0)
			step = -step;
		if (window_held == 0 || step > int'(jump_lim_cfg)) begin
			ring_oldest = 0;
			window_held = 1;
			ring_slots[0] = raw;
			window_sum = s;
		end else begin
			if (window_held + 1 > win) begin
				window_sum -= int'($signed(ring_slots[ring_oldest]));
				ring_oldest = (ring_oldest + 1) % MAX_WINDOW_DEF;
				window_held -= 1;
			end
			ring_slots[(ring_oldest + window_held) % MAX_WINDOW_DEF] = raw;
			window_sum += s;
			window_held += 1;
		end
		last_sample = s;
		avg = window_sum / window_held;
		res.average = avg[SAMPLE_W-1:0];
		res.fill_count = window_held[FILL_W-1:0];
		avg_expect_q.push_back(res);
	endtask

	// sample driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			tx_wait <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				advance_window(s_axis_tdata);
			if (s_axis_tvalid && !s_axis_tready) begin
			end else if (tx_wait != 0) begin
				s_axis_tvalid <= 1'b0;
				tx_wait <= tx_wait - 1;
			end else if (sample_q.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= sample_q.pop_front();
				tx_wait <= draw_gap(tx_burst);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (avg_expect_q.size() == 0) begin
					$display("%0t: unexpected result beat: average %0d fill_count %0d", $time,
						$signed(m_axis_tdata[SAMPLE_W-1:0]), m_axis_tdata[SAMPLE_W +: FILL_W]);
					fail_count++;
				end else begin
					exp_res = avg_expect_q.pop_front();
					if (m_axis_tdata[SAMPLE_W-1:0] !== exp_res.average) begin
						$display("%0t: average mismatch: expected %0d actual %0d", $time,
							$signed(exp_res.average), $signed(m_axis_tdata[SAMPLE_W-1:0]));
						fail_count++;
					end
					if (m_axis_tdata[SAMPLE_W +: FILL_W] !== exp_res.fill_count) begin
						$display("%0t: fill_count mismatch: expected %0d actual %0d", $time,
							exp_res.fill_count, m_axis_tdata[SAMPLE_W +: FILL_W]);
						fail_count++;
					end
				end
			end
			if (long_hold_req && !long_hold_done) begin
				m_axis_tready <= 1'b0;
				hold_count <= hold_count + 1;
				if (hold_count == LONG_HOLD)
					long_hold_done <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				rx_gap = draw_gap(rx_burst);
				rx_wait <= rx_gap;
				m_axis_tready <= (rx_gap == 0);
			end else if (rx_wait != 0) begin
				rx_wait <= rx_wait - 1;
				m_axis_tready <= (rx_wait == 1);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_WINDOW_LEN)
			win_len_cfg = val[WLEN_W-1:0];
		else
			jump_lim_cfg = val[JLIM_W-1:0];
	endtask

	task automatic drain();
		while (sample_q.size() != 0 || s_axis_tvalid || avg_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic push_sample(input int v);
		sample_q.push_back(v[SAMPLE_W-1:0]);
		walk_pos = v;
	endtask

	task automatic push_walk(input int n, input int jump_pct);
		int r;
		int step;
		int jl;
		int next;
		jl = int'(jump_lim_cfg);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < jump_pct) begin
				next = int'($urandom_range(0, 65535)) - 32768;
			end else if (r < jump_pct + 3) begin
				next = $urandom_range(0, 1) ? 32767 : -32768;
			end else begin
				if (r < jump_pct + 10)
					step = jl + $urandom_range(0, 1);
				else
					step = $urandom_range(0, jl);
				if ($urandom_range(0, 1))
					step = -step;
				next = walk_pos + step;
				if (next > 32767)
					next = 32767;
				if (next < -32768)
					next = -32768;
			end
			push_sample(next);
		end
	endtask

	initial begin
		int wl;
		int jl;
		int jump_pct;
		logic [CFG_DATA_W-1:0] wdat;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: step equal to limit, step past it, overflow of the window
		push_sample(0);
		push_sample(41);
		push_sample(0);
		push_sample(42);
		for (int v = 43; v <= 52; v++)
			push_sample(v);
		push_sample(-3);
		push_sample(-4);
		push_sample(32767);
		push_sample(-32768);
		drain();

		// zero window length, zero jump limit
		write_reg(REG_WINDOW_LEN, '0);
		write_reg(REG_JUMP_LIMIT, '0);
		push_sample(5);
		push_sample(5);
		push_sample(6);
		push_sample(-32768);
		push_sample(-32768);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			jump_pct = $urandom_range(0, 15);
			case (p)
				0: begin wl = 31; jl = 32767; jump_pct = 0; end
				1: begin wl = 16; jl = 32767; jump_pct = 0; end
				2: begin wl = 3;  jl = 32767; jump_pct = 1; end
				3: begin wl = 1;  jl = 0; end
				4: begin wl = 16; jl = 0; jump_pct = 0; end
				5: begin wl = 0;  jl = 1000; end
				default: begin
					wl = $urandom_range(0, 31);
					case ($urandom_range(0, 2))
						0: jl = $urandom_range(0, 63);
						1: jl = $urandom_range(0, 1023);
						default: jl = $urandom_range(0, 32767);
					endcase
				end
			endcase
			if (p < 6 || $urandom_range(0, 2) != 0) begin
				wdat = CFG_DATA_W'($urandom);
				wdat[WLEN_W-1:0] = wl[WLEN_W-1:0];
				write_reg(REG_WINDOW_LEN, wdat);
			end
			if (p < 6 || $urandom_range(0, 2) != 0)
				write_reg(REG_JUMP_LIMIT, jl[CFG_DATA_W-1:0]);
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			if (p == 10) begin
				tx_burst = 1'b1;
				long_hold_req = 1'b1;
			end
			push_walk(PHASE_ITEMS, jump_pct);
			drain();
		end

		if (fail_count == 0 && avg_expect_q.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/mawjr_pkg.sv
hw/rtl/mawjr_front.sv
hw/rtl/mawjr_fifo.sv
hw/rtl/mawjr_back.sv
hw/rtl/moving_average_with_jump_reset.sv
tb/sv/tb.sv
